// ===== rtl/khr_pkg.sv =====
`default_nettype none

package khr_pkg;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int LIMIT_W  = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [LIMIT_W-1:0]  limit_t;

    // Operation codes.
    localparam func_t F_FIND   = 2'd0;
    localparam func_t F_BIND   = 2'd1;
    localparam func_t F_UNBIND = 2'd2;
    localparam func_t F_RSVD   = 2'd3;

    // Status codes.
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_NOT_FOUND = 3'd1;
    localparam status_t ST_PRESENT   = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_INVALID   = 3'd4;

    // Register word indexes.
    localparam logic REG_CAPACITY_LIMIT = 1'b0;

    localparam limit_t CAPACITY_RESET = 5'd16;

    // One table entry.
    typedef struct packed {
        key_t    key;
        handle_t handle;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/khr_if.sv =====
`default_nettype none

interface khr_req_if import khr_pkg::*; ();
    logic    valid;
    logic    ready;
    func_t   func;
    key_t    lookup_key;
    handle_t handle_in;

    modport source (output valid, output func, output lookup_key, output handle_in,
                    input ready);
    modport sink (input valid, input func, input lookup_key, input handle_in,
                  output ready);
endinterface

interface khr_rsp_if import khr_pkg::*; ();
    logic    valid;
    logic    ready;
    status_t status;
    handle_t handle_out;
    count_t  entry_count;

    modport source (output valid, output status, output handle_out, output entry_count,
                    input ready);
    modport sink (input valid, input status, input handle_out, input entry_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/keyed_handle_registry_core.sv =====
// Sequence: an item reads and compares each entry in turn; an unbind that hits then shifts each
// later entry down one place with a read and a write, and a finish step returns the word.
// Throughput: one item at a time; the single-port entry table and the scan/shift sequencer set
// the rate. A finished word waits in the output register while the next item is taken.
// Reset: rst_n clears the entry count, the sequencer and the output valid, and sets the
// capacity limit to 16. The table contents are not cleared; only entries below the count are read.
`default_nettype none

module keyed_handle_registry_core import khr_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    khr_req_if.sink                 req,
    khr_rsp_if.source               rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    limit_t           capacity_limit;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_wdata;
    entry_t           mem_rdata;

    khr_apb u_apb (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .capacity_limit (capacity_limit)
    );

    khr_table #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    khr_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .capacity_limit (capacity_limit),
        .req            (req),
        .rsp            (rsp),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/khr_apb.sv =====
`default_nettype none

module khr_apb import khr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output limit_t                  capacity_limit
);

    limit_t cap_reg;
    logic   wr_en;

    // Address bit 2 selects the word; the low bits are byte offsets.
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CAPACITY_LIMIT);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAPACITY_RESET;
        end
        else if (wr_en)
        begin
            cap_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY_LIMIT)
        begin
            prdata = {{(PDATA_W-LIMIT_W){1'b0}}, cap_reg};
        end
    end

    assign capacity_limit = cap_reg;

endmodule

`default_nettype wire

// ===== rtl/khr_table.sv =====
`default_nettype none

module khr_table import khr_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire entry_t           wdata,
    input  wire logic [IDX_W-1:0] raddr,
    output entry_t                rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/khr_ctrl.sv =====
`default_nettype none

module khr_ctrl import khr_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5,
    parameter int IDX_W = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire limit_t           capacity_limit,
    khr_req_if.sink               req,
    khr_rsp_if.source             rsp,
    output logic                  mem_we,
    output logic      [IDX_W-1:0] mem_waddr,
    output entry_t                mem_wdata,
    output logic      [IDX_W-1:0] mem_raddr,
    input  wire entry_t           mem_rdata
);

    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_SHRD = 3'd3;
    localparam logic [2:0] S_SHWR = 3'd4;
    localparam logic [2:0] S_MISS = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    func_t            func_reg, func_next;
    key_t             key_reg, key_next;
    handle_t          hdl_reg, hdl_next;
    status_t          status_reg, status_next;
    handle_t          hout_reg, hout_next;

    logic             rsp_valid_reg, rsp_valid_next;
    status_t          rsp_status_reg, rsp_status_next;
    handle_t          rsp_handle_reg, rsp_handle_next;
    count_t           rsp_count_reg, rsp_count_next;

    logic [CNT_W-1:0] nxt_idx;
    logic [CNT_W-1:0] nxt2_idx;
    logic [CMP_W-1:0] cap_ext, depth_ext, limit_eff, count_ext;
    logic             full;
    logic             bad_args;

    assign nxt_idx  = idx_reg + CNT_W'(1);
    assign nxt2_idx = idx_reg + CNT_W'(2);

    assign cap_ext   = CMP_W'(capacity_limit);
    assign depth_ext = CMP_W'(DEPTH);
    assign limit_eff = (cap_ext < depth_ext) ? cap_ext : depth_ext;
    assign count_ext = CMP_W'(count_reg);
    assign full      = (count_ext >= limit_eff);

    assign bad_args = (req.lookup_key == '0) || (req.func == F_RSVD)
                   || ((req.func == F_BIND) && (req.handle_in == '0));

    assign req.ready = (state_reg == S_IDLE);

    // Memory port: the scan reads at idx, the shift reads one above and writes at idx.
    assign mem_raddr = (state_reg == S_SHRD) ? nxt_idx[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign mem_we    = (state_reg == S_SHWR)
                    || ((state_reg == S_MISS) && (func_reg == F_BIND) && !full);
    assign mem_waddr = (state_reg == S_SHWR) ? idx_reg[IDX_W-1:0] : count_reg[IDX_W-1:0];
    assign mem_wdata = (state_reg == S_SHWR) ? mem_rdata : entry_t'{key_reg, hdl_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        hdl_next        = hdl_reg;
        status_next     = status_reg;
        hout_next       = hout_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_handle_next = rsp_handle_reg;
        rsp_count_next  = rsp_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next = req.func;
                    key_next  = req.lookup_key;
                    hdl_next  = req.handle_in;
                    idx_next  = '0;
                    hout_next = '0;
                    if (bad_args)
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_FIN;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (mem_rdata.key == key_reg)
                begin
                    case (func_reg)
                        F_FIND:
                        begin
                            status_next = ST_OK;
                            hout_next   = mem_rdata.handle;
                            state_next  = S_FIN;
                        end
                        F_BIND:
                        begin
                            status_next = ST_PRESENT;
                            state_next  = S_FIN;
                        end
                        default:
                        begin
                            if (nxt_idx < count_reg)
                            begin
                                state_next = S_SHRD;
                            end
                            else
                            begin
                                count_next  = count_reg - CNT_W'(1);
                                status_next = ST_OK;
                                state_next  = S_FIN;
                            end
                        end
                    endcase
                end
                else if (nxt_idx == count_reg)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    idx_next   = nxt_idx;
                    state_next = S_RD;
                end
            end
            S_SHRD:
            begin
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                idx_next = nxt_idx;
                if (nxt2_idx < count_reg)
                begin
                    state_next = S_SHRD;
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(1);
                    status_next = ST_OK;
                    state_next  = S_FIN;
                end
            end
            S_MISS:
            begin
                if (func_reg == F_BIND)
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next  = count_reg + CNT_W'(1);
                        status_next = ST_OK;
                    end
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Wait here until the output register is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_handle_next = hout_reg;
                    rsp_count_next  = count_ext[COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        func_reg       <= func_next;
        key_reg        <= key_next;
        hdl_reg        <= hdl_next;
        status_reg     <= status_next;
        hout_reg       <= hout_next;
        rsp_status_reg <= rsp_status_next;
        rsp_handle_reg <= rsp_handle_next;
        rsp_count_reg  <= rsp_count_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.handle_out  = rsp_handle_reg;
    assign rsp.entry_count = rsp_count_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_ext <= depth_ext)
        else $error("entry count exceeds table depth");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CMP && state_reg != S_SHWR && state_reg != S_MISS)
            |=> (count_reg == $past(count_reg)))
        else $error("entry count changed outside an update step");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_CMP || state_reg == S_SHRD
            || state_reg == S_SHWR) |-> (idx_reg < count_reg))
        else $error("scan index beyond valid entries");

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("response word raised outside the finish step");

endmodule

`default_nettype wire
